>>> sv/flt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// File lock level table package
// Shared types, operation and status codes, and lock level constants.
// ----------------------------------------------------------------------------
package flt_pkg;

  // One lock level: 0 none up to 4 exclusive.
  typedef logic [2:0] level_t;

  localparam level_t LVL_NONE      = 3'd0;
  localparam level_t LVL_SHARED    = 3'd1;
  localparam level_t LVL_RESERVED  = 3'd2;
  localparam level_t LVL_PENDING   = 3'd3;
  localparam level_t LVL_EXCLUSIVE = 3'd4;

  // Request operations.
  typedef enum logic [1:0] {
    FUNC_LOCK   = 2'd0,
    FUNC_UNLOCK = 2'd1,
    FUNC_COUNT  = 2'd2,
    FUNC_CLOSE  = 2'd3
  } func_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Operations of the shared level comparator.
  typedef enum logic {
    CMP_GE = 1'b0,
    CMP_GT = 1'b1
  } cmp_op_e;

  // Highest level that other clients may hold when one client wants a level.
  function automatic level_t allowed_other(input level_t want);
    level_t cap;
    case (want)
      LVL_EXCLUSIVE: cap = LVL_NONE;
      LVL_PENDING:   cap = LVL_RESERVED;
      LVL_RESERVED:  cap = LVL_SHARED;
      LVL_SHARED:    cap = LVL_SHARED;
      default:       cap = LVL_EXCLUSIVE;
    endcase
    return cap;
  endfunction

endpackage
`default_nettype wire

>>> sv/file_lock_level_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// File lock level table
// Per-client lock levels with lock, unlock, count and close requests.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_axis channel and one response leaves on the
// m_axis channel for every request. s_axis_tready is high only while the
// sequencer is idle; one request is worked on at a time.
// Lock levels live in a small memory with one read and one write port, and a
// single comparator checks one level per cycle under a small sequencer.
// Close, unlock and a lock that the client already holds read and check the
// own level, then raise the response. A lock that must check other clients
// walks all CLIENTS entries, one per cycle, then drains the last read and
// grants or refuses the lock; a count request skips the own-level read and
// scans at once. A non-count request for a client outside the table goes
// straight to the response step with an error status.
// The response sits in an output register: a new request is accepted while
// it waits, and a stalled receiver holds only the final step of the next
// request. Reset clears the memory valid bits, so every client starts with
// no lock, and drops any pending response.
// ----------------------------------------------------------------------------
module file_lock_level_table #(
  parameter int CLIENTS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // func [1:0], client [4:2], level [7:5]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // status [1:0], reserved_count [5:2], zero [7:6]
);

  localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int AW    = (IDX_W > 3) ? IDX_W : 3;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OWN   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]        state_q, state_d;
  flt_pkg::func_e    func_q, func_d;
  logic [2:0]        client_q, client_d;
  flt_pkg::level_t   want_q, want_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              busy_q, busy_d;
  logic [3:0]        cnt_q, cnt_d;
  flt_pkg::status_e  res_status_q, res_status_d;
  logic              m_valid_q, m_valid_d;
  logic [7:0]        m_data_q, m_data_d;

  logic [1:0]        in_func;
  logic [2:0]        in_client;
  flt_pkg::level_t   in_level, in_want;
  logic              in_accept, in_client_ok;
  logic [AW-1:0]     client_ext;
  logic [IDX_W-1:0]  client_addr;
  flt_pkg::level_t   cap;

  logic              wr_en;
  flt_pkg::level_t   wr_data;
  logic [IDX_W-1:0]  rd_addr;
  flt_pkg::level_t   rd_data;

  flt_pkg::level_t   cmp_b;
  flt_pkg::cmp_op_e  cmp_op;
  logic              cmp_hit;

  // Unpack the request and clamp levels above exclusive.
  assign in_func      = s_axis_tdata[1:0];
  assign in_client    = s_axis_tdata[4:2];
  assign in_level     = s_axis_tdata[7:5];
  assign in_want      = (in_level > flt_pkg::LVL_EXCLUSIVE) ? flt_pkg::LVL_EXCLUSIVE
                                                            : in_level;
  assign in_client_ok = (32'(in_client) < 32'(CLIENTS));
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign client_ext  = AW'(client_q);
  assign client_addr = client_ext[IDX_W-1:0];
  assign cap         = flt_pkg::allowed_other(want_q);

  // Memory read address: the own entry, or the entry under scan.
  assign rd_addr = (state_q == S_SCAN) ? idx_q : client_addr;

  flt_level_mem #(
    .CLIENTS (CLIENTS),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (client_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Comparator operand selection: own level against the request, or a
  // scanned level against the cap of the lock or the reserved threshold.
  always_comb begin
    if (state_q == S_CHK) begin
      cmp_b  = want_q;
      cmp_op = flt_pkg::CMP_GE;
    end else if (func_q == flt_pkg::FUNC_LOCK) begin
      cmp_b  = cap;
      cmp_op = flt_pkg::CMP_GT;
    end else begin
      cmp_b  = flt_pkg::LVL_RESERVED;
      cmp_op = flt_pkg::CMP_GE;
    end
  end

  flt_cmp u_cmp (
    .a_i   (rd_data),
    .b_i   (cmp_b),
    .op_i  (cmp_op),
    .hit_o (cmp_hit)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    client_d     = client_q;
    want_d       = want_q;
    idx_d        = idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    wr_en        = 1'b0;
    wr_data      = want_q;

    // Evaluate the entry read in the previous scan cycle.
    if (chk_vld_q && cmp_hit) begin
      if (func_q == flt_pkg::FUNC_LOCK) begin
        if (chk_idx_q != client_addr) begin
          busy_d = 1'b1;
        end
      end else if (cnt_q != 4'hF) begin
        cnt_d = cnt_q + 4'd1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          func_d       = flt_pkg::func_e'(in_func);
          client_d     = in_client;
          want_d       = in_want;
          idx_d        = '0;
          busy_d       = 1'b0;
          cnt_d        = '0;
          res_status_d = flt_pkg::ST_OK;
          if (flt_pkg::func_e'(in_func) == flt_pkg::FUNC_COUNT) begin
            state_d = S_SCAN;
          end else if (!in_client_ok) begin
            res_status_d = flt_pkg::ST_ERROR;
            state_d      = S_RESP;
          end else begin
            state_d = S_OWN;
          end
        end
      end
      S_OWN: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = S_RESP;
        case (func_q)
          flt_pkg::FUNC_LOCK: begin
            if (!cmp_hit) begin
              state_d = S_SCAN;
            end
          end
          flt_pkg::FUNC_UNLOCK: begin
            if (cmp_hit) begin
              wr_en = 1'b1;
            end else begin
              res_status_d = flt_pkg::ST_ERROR;
            end
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = flt_pkg::LVL_NONE;
          end
        endcase
      end
      S_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        idx_d     = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINAL;
      end
      S_FINAL: begin
        if (func_q == flt_pkg::FUNC_LOCK) begin
          if (busy_q) begin
            res_status_d = flt_pkg::ST_BUSY;
          end else begin
            wr_en = 1'b1;
          end
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00,
                       (func_q == flt_pkg::FUNC_COUNT) ? cnt_q : 4'd0,
                       res_status_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    client_q     <= client_d;
    want_q       <= want_d;
    idx_q        <= idx_d;
    chk_idx_q    <= chk_idx_d;
    busy_q       <= busy_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // The table is written only after the own level or the scan was checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_CHK || state_q == S_FINAL))
    else $error("lock table written outside a check step");

  // A new response appears only from the response step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_RESP))
    else $error("response raised outside the response step");

  // Scanned entries are only evaluated while scanning or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("scan result evaluated outside the scan");
`endif

endmodule
`default_nettype wire

>>> sv/flt_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Level comparator
// The one compare unit shared by the own-level check and the scan.
// ----------------------------------------------------------------------------
module flt_cmp (
  input  flt_pkg::level_t  a_i,
  input  flt_pkg::level_t  b_i,
  input  flt_pkg::cmp_op_e op_i,
  output logic             hit_o
);

  // Greater-or-equal or strictly greater, as the sequencer selects.
  always_comb begin
    unique case (op_i)
      flt_pkg::CMP_GT: hit_o = (a_i > b_i);
      default:         hit_o = (a_i >= b_i);
    endcase
  end

endmodule
`default_nettype wire

>>> sv/flt_level_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Lock level memory
// One write and one registered read port; valid bits make unwritten entries
// read as no lock after reset.
// ----------------------------------------------------------------------------
module flt_level_mem #(
  parameter int CLIENTS = 8,
  parameter int IDX_W   = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  flt_pkg::level_t   wr_data_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output flt_pkg::level_t   rd_data_o
);

  flt_pkg::level_t    mem_q [CLIENTS];
  logic [CLIENTS-1:0] valid_q;

  // Valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_o <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : flt_pkg::LVL_NONE;
  end

endmodule
`default_nettype wire
